FILE: rtl/bcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, constants and functions of the Bech32 checksum engine.
// ----------------------------------------------------------------------------
package bcs_pkg;

   // Queue between the front and back parts.
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // Generator rows of the BCH residue update.
   localparam logic [4:0][29:0] GEN = {
      30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
   };

   // Alphabet characters, symbol 0 in the lowest slot.
   localparam logic [31:0][6:0] ALPHABET = {
      7'h6c, 7'h37, 7'h61, 7'h75, 7'h6d, 7'h36, 7'h65, 7'h63,
      7'h68, 7'h6b, 7'h34, 7'h35, 7'h6e, 7'h6a, 7'h33, 7'h73,
      7'h30, 7'h77, 7'h64, 7'h76, 7'h74, 7'h32, 7'h66, 7'h67,
      7'h38, 7'h78, 7'h39, 7'h79, 7'h72, 7'h7a, 7'h70, 7'h71
   };

   localparam logic [29:0] RESIDUE_ONE = 30'd1;

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic       good;
      logic [4:0] sym;
      logic       last;
   } entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Result of mapping a character through the alphabet.
   typedef struct packed {
      logic       good;
      logic [4:0] sym;
   } lookup_type;

   // One step of the residue: shift in a symbol, fold the top group back.
   function automatic logic [29:0] absorb(input logic [29:0] r, input logic [4:0] sym);
      logic [29:0] n;
      n = {r[24:0], 5'b0} ^ {25'b0, sym};
      for (int b = 0; b < 5; b++) begin
         if (r[25 + b]) begin
            n = n ^ GEN[b];
         end
      end
      return n;
   endfunction

   // Map an ASCII code to its symbol; upper case maps like lower case.
   function automatic lookup_type char_to_sym(input logic [7:0] ch);
      lookup_type  res;
      logic [6:0]  lc;
      res = '0;
      lc  = ch[6:0];
      if (lc >= 7'h41 && lc <= 7'h5a) begin
         lc = lc + 7'h20;
      end
      for (int i = 0; i < 32; i++) begin
         if (ALPHABET[i] == lc) begin
            res.good = 1'b1;
            res.sym  = 5'(i);
         end
      end
      if (ch[7]) begin
         res.good = 1'b0;
      end
      return res;
   endfunction

endpackage

FILE: rtl/bcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_front
// Accepts requests, maps characters to symbols and feeds the queue.
// ----------------------------------------------------------------------------
module bcs_front import bcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_value,
   input  logic       req_last,
   input  qstat_type  q_stat,
   output logic       push_valid,
   output entry_type  push_entry
);

   logic       fr_valid_ff, fr_valid_in;
   entry_type  fr_entry_ff, fr_entry_in;
   lookup_type look;
   logic       accept;

   // The holding stage stalls only when it is full and the queue is full.
   assign req_stall = fr_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Classify the request: a raw symbol is always good.
   always_comb begin
      look = char_to_sym(req_value);
      fr_entry_in.last = req_last;
      if (req_func) begin
         fr_entry_in.good = look.good;
         fr_entry_in.sym  = look.sym;
      end else begin
         fr_entry_in.good = 1'b1;
         fr_entry_in.sym  = req_value[4:0];
      end
   end

   // The stage empties into the queue whenever the queue has room.
   always_comb begin
      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (!q_stat.full) begin
         fr_valid_in = 1'b0;
      end else begin
         fr_valid_in = fr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_entry_ff <= fr_entry_in;
      end
   end

   assign push_valid = fr_valid_ff;
   assign push_entry = fr_entry_ff;

endmodule

FILE: rtl/bcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module bcs_queue import bcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  entry_type  push_entry,
   input  logic       pop_req,
   output entry_type  head_entry,
   output qstat_type  q_stat
);

   entry_type      mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           do_push, do_pop;

   assign q_stat.full  = (count_ff == (QAW+1)'(QDEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push_valid && !q_stat.full;
   assign do_pop       = pop_req && !q_stat.empty;
   assign head_entry   = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/bcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_back
// Runs the residue, finishes each message and drives the response register.
// ----------------------------------------------------------------------------
module bcs_back import bcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  entry_type  head_entry,
   input  qstat_type  q_stat,
   output logic       pop_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_symbol,
   output logic [6:0] rsp_symbol_char,
   output logic       rsp_checksum_ok,
   output logic       rsp_bad_char,
   output logic       rsp_last_symbol
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_VER  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic        mode_ff;
   logic [29:0] residue_ff, residue_in;
   logic        bad_ff, bad_in;
   logic [1:0]  state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [29:0] fin_r_ff, fin_r_in;
   logic        fin_bad_ff, fin_bad_in;
   logic        out_valid_ff, out_valid_in;
   logic [4:0]  out_sym_ff, out_sym_in;
   logic [6:0]  out_char_ff, out_char_in;
   logic        out_ok_ff, out_ok_in;
   logic        out_bad_ff, out_bad_in;
   logic        out_last_ff, out_last_in;
   logic        out_free, out_load;
   logic [29:0] res_next;
   logic        bad_next;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // A last request waits until the finisher is free.
   assign pop_req  = !q_stat.empty && (!head_entry.last || state_ff == ST_IDLE);
   assign out_free = !out_valid_ff || !rsp_stall;

   // Residue and sticky flag after the head request.
   always_comb begin
      res_next = head_entry.good ? absorb(residue_ff, head_entry.sym) : residue_ff;
      bad_next = bad_ff || !head_entry.good;
      residue_in = residue_ff;
      bad_in     = bad_ff;
      if (pop_req) begin
         if (head_entry.last) begin
            residue_in = RESIDUE_ONE;
            bad_in     = 1'b0;
         end else begin
            residue_in = res_next;
            bad_in     = bad_next;
         end
      end
   end

   // Finisher sequencer: verify reports once, create absorbs six zeros and
   // then emits six symbols, high group first.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      fin_r_in    = fin_r_ff;
      fin_bad_in  = fin_bad_ff;
      out_load    = 1'b0;
      out_sym_in  = 5'd0;
      out_char_in = 7'd0;
      out_ok_in   = 1'b0;
      out_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_req && head_entry.last) begin
               fin_r_in   = res_next;
               fin_bad_in = bad_next;
               cnt_in     = 3'd0;
               state_in   = mode_ff ? ST_ZERO : ST_VER;
            end
         end
         ST_VER: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_ok_in   = (fin_r_ff == RESIDUE_ONE);
               out_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (cnt_ff == 3'd5) begin
               fin_r_in = absorb(fin_r_ff, 5'd0) ^ RESIDUE_ONE;
               cnt_in   = 3'd0;
               state_in = ST_EMIT;
            end else begin
               fin_r_in = absorb(fin_r_ff, 5'd0);
               cnt_in   = cnt_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_sym_in  = fin_r_ff[29:25];
               out_char_in = ALPHABET[fin_r_ff[29:25]];
               out_last_in = (cnt_ff == 3'd5);
               fin_r_in    = {fin_r_ff[24:0], 5'b0};
               if (cnt_ff == 3'd5) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_bad_in   = fin_bad_ff;
   assign out_valid_in = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff   <= RESIDUE_ONE;
         bad_ff       <= 1'b0;
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         residue_ff   <= residue_in;
         bad_ff       <= bad_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Finisher and response payload.
   always_ff @(posedge clock) begin
      fin_r_ff   <= fin_r_in;
      fin_bad_ff <= fin_bad_in;
      if (out_load) begin
         out_sym_ff  <= out_sym_in;
         out_char_ff <= out_char_in;
         out_ok_ff   <= out_ok_in;
         out_bad_ff  <= out_bad_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_symbol      = out_sym_ff;
   assign rsp_symbol_char = out_char_ff;
   assign rsp_checksum_ok = out_ok_ff;
   assign rsp_bad_char    = out_bad_ff;
   assign rsp_last_symbol = out_last_ff;

endmodule

FILE: rtl/bech32_checksum_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bech32_checksum_engine_core
// Bech32 BCH checksum engine: verifies or creates the six-symbol checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Each request carries either a raw 5-bit symbol (func 0, used for the
//   expanded human-readable part) or a data character (func 1). The request
//   marked last ends the message. Both channels move a request when valid is
//   high and stall is low. The csr port writes the mode: 0 verify, 1 create.
//   Verify mode gives one response with checksum_ok; create mode gives six
//   responses with the checksum symbols and their characters. bad_char
//   flags any character outside the alphabet in the message.
//   Throughput is one request per cycle while req_stall is low. A last
//   request leaves the queue only while the finisher is idle. The first
//   response passes the front holding stage, the queue, the finisher and
//   the response register. The create finisher absorbs six zeros and then
//   emits six symbols; the verify finisher gives one response. A following
//   last request waits in the queue while the finisher is busy. Other
//   requests keep flowing meanwhile.
//   Reset clears the residue to one, the flag, the queue and the mode.
//   When the receiver stalls the response register holds its value; the
//   queue fills and then req_stall rises.
// ----------------------------------------------------------------------------
module bech32_checksum_engine_core import bcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_value,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_symbol,
   output logic [6:0] rsp_symbol_char,
   output logic       rsp_checksum_ok,
   output logic       rsp_bad_char,
   output logic       rsp_last_symbol
);

   logic      push_valid;
   entry_type push_entry;
   entry_type head_entry;
   qstat_type q_stat;
   logic      pop_req;

   // Front part: accept and classify.
   bcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_value  (req_value),
      .req_last   (req_last),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Queue between the two parts.
   bcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop_req    (pop_req),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   // Back part: residue, finisher and response register.
   bcs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .head_entry      (head_entry),
      .q_stat          (q_stat),
      .pop_req         (pop_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_symbol (rsp_last_symbol)
   );

   // The queue is never full and empty at once.
   assert property (@(posedge clock) disable iff (reset) !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   // A passing verify result is always the final response of its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_last_symbol)
      else $error("checksum_ok on a response that is not last");

   // Responses before the last one are create-mode symbols with a character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_symbol |-> rsp_symbol_char != 7'd0 && !rsp_checksum_ok)
      else $error("non-final response without a checksum character");

   // No response is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bech32 checksum engine core.
//
// Requests are raw symbols and data characters that form messages, and the
// mode register switches between checking a received checksum and producing
// a new one. A short table of hand-picked requests comes first, including a
// known valid address, then a few dozen random messages. Most of them are
// well formed, some are corrupted, and some are pure noise. Every accepted
// request updates a local copy of the residue and flag. Responses are
// matched in order against the expected queue, under random gaps on both
// channels and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

   // Request kinds and engine modes.
   typedef enum logic {FUNC_RAW = 1'b0, FUNC_CHAR = 1'b1} req_func_type;
   typedef enum logic {MODE_VERIFY = 1'b0, MODE_CREATE = 1'b1} engine_mode_type;

   typedef struct packed {
      req_func_type func;
      logic [7:0]   value;
      logic         last;
   } request_type;

   typedef struct packed {
      logic [4:0] symbol;
      logic [6:0] symbol_char;
      logic       checksum_ok;
      logic       bad_char;
      logic       last_symbol;
   } response_type;

   // One row of the directed table; the hand fields hold a typed expectation.
   typedef struct packed {
      engine_mode_type mode;
      request_type     rq;
      logic            by_hand;
      logic            hand_ok;
      logic            hand_bad;
      logic [47:0]     hand_chars;
   } directed_row_type;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int LONG_HOLD     = 80;
   localparam int PHASE_ITEMS   = 48;
   localparam int MAX_REPORTS   = 10;
   localparam longint TIMEOUT_NS = 10_000_000;

   localparam logic [47:0] NO_CHARS = 48'h0;
   localparam logic [29:0] RESIDUE_INIT = 30'd1;
   localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [29:0] BCH_GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [7:0] req_value;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [4:0] rsp_symbol;
   logic [6:0] rsp_symbol_char;
   logic       rsp_checksum_ok;
   logic       rsp_bad_char;
   logic       rsp_last_symbol;

   // Local copy of the engine state.
   logic [29:0]     model_residue = RESIDUE_INIT;
   logic            model_bad = 1'b0;
   engine_mode_type model_mode = MODE_VERIFY;

   response_type awaited_responses[$];
   response_type predicted[$];
   directed_row_type directed_rows [24];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked = 0;
   int errors = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int verify_msgs = 0;
   int verify_good = 0;
   int create_msgs = 0;
   int bad_msgs = 0;

   bech32_checksum_engine_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_symbol_char (rsp_symbol_char),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_symbol (rsp_last_symbol)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Shift one symbol into the residue and fold the top group back in.
   function automatic logic [29:0] bch_shift(input logic [29:0] r, input logic [4:0] s);
      logic [29:0] n;
      n = {r[24:0], s};
      for (int b = 0; b < 5; b++) begin
         if (r[25 + b]) begin
            n = n ^ BCH_GEN[b];
         end
      end
      return n;
   endfunction

   // The six checksum symbols, high group first, packed into 30 bits.
   function automatic logic [29:0] checksum_code(input logic [29:0] r);
      logic [29:0] n;
      n = r;
      for (int k = 0; k < 6; k++) begin
         n = bch_shift(n, 5'd0);
      end
      return n ^ RESIDUE_INIT;
   endfunction

   // Alphabet index of a character; bit 5 set means it is not in the alphabet.
   function automatic logic [5:0] symbol_of_char(input logic [7:0] ch);
      logic [7:0] lc;
      logic [5:0] found;
      lc = ch;
      found = 6'd32;
      if (lc >= "A" && lc <= "Z") begin
         lc = lc + 8'd32;
      end
      for (int i = 0; i < 32; i++) begin
         if (CHARSET[8 * (31 - i) +: 8] == lc) begin
            found = 6'(i);
         end
      end
      return found;
   endfunction

   function automatic logic [7:0] char_of_symbol(input logic [4:0] s);
      return CHARSET[8 * (31 - int'(s)) +: 8];
   endfunction

   // Absorb one accepted request and list the responses it should cause.
   task automatic predict_engine(input request_type rq);
      logic [5:0]   sym;
      logic [29:0]  code;
      logic [7:0]   ch;
      response_type rs;
      predicted.delete();
      if (rq.func == FUNC_RAW) begin
         model_residue = bch_shift(model_residue, rq.value[4:0]);
      end else begin
         sym = symbol_of_char(rq.value);
         if (sym[5]) begin
            model_bad = 1'b1;
         end else begin
            model_residue = bch_shift(model_residue, sym[4:0]);
         end
      end
      if (rq.last) begin
         if (model_bad) begin
            bad_msgs++;
         end
         if (model_mode == MODE_VERIFY) begin
            rs = '{5'd0, 7'd0, model_residue == RESIDUE_INIT, model_bad, 1'b1};
            predicted.insert(predicted.size(), rs);
            verify_msgs++;
            verify_good += int'(rs.checksum_ok);
         end else begin
            code = checksum_code(model_residue);
            for (int k = 0; k < 6; k++) begin
               ch = char_of_symbol(code[5 * (5 - k) +: 5]);
               rs = '{code[5 * (5 - k) +: 5], ch[6:0], 1'b0, model_bad, k == 5};
               predicted.insert(predicted.size(), rs);
            end
            create_msgs++;
         end
         model_residue = RESIDUE_INIT;
         model_bad = 1'b0;
      end
   endtask

   // Offer one request, with random idle cycles first; entered and left at a
   // falling edge. Valid stays high afterwards so back-to-back requests flow.
   task automatic offer_request(input request_type rq, input bit by_hand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= rq.func;
      req_value <= rq.value;
      req_last  <= rq.last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_engine(rq);
      if (!by_hand) begin
         foreach (predicted[k]) begin
            awaited_responses.insert(awaited_responses.size(), predicted[k]);
         end
      end
      requests_sent++;
      @(negedge clock);
   endtask

   // Let the engine go idle, then write the mode register.
   task automatic write_mode(input engine_mode_type m);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we    <= 1'b0;
      model_mode = m;
   endtask

   // One random message: mostly a well-formed address with random content,
   // sometimes corrupted, sometimes plain noise.
   task automatic offer_message();
      request_type msg[$];
      request_type rq;
      logic [7:0]  hrp [4];
      logic [7:0]  ch;
      logic [29:0] acc;
      logic [29:0] code;
      logic [4:0]  s;
      logic        upper;
      int          pick;
      int          n_hrp;
      pick = $urandom_range(99);
      if (pick < 20) begin
         repeat ($urandom_range(1, 6)) begin
            rq = '{req_func_type'($urandom_range(1)), 8'($urandom), 1'b0};
            msg.insert(msg.size(), rq);
         end
      end else begin
         // Expanded human-readable part as raw symbols; junk in the top bits.
         acc = RESIDUE_INIT;
         n_hrp = $urandom_range(1, 4);
         for (int i = 0; i < n_hrp; i++) begin
            hrp[i] = 8'($urandom_range(33, 126));
            s = {3'b000, hrp[i][6:5]};
            rq = '{FUNC_RAW, {3'($urandom), s}, 1'b0};
            msg.insert(msg.size(), rq);
            acc = bch_shift(acc, s);
         end
         rq = '{FUNC_RAW, {3'($urandom), 5'd0}, 1'b0};
         msg.insert(msg.size(), rq);
         acc = bch_shift(acc, 5'd0);
         for (int i = 0; i < n_hrp; i++) begin
            s = hrp[i][4:0];
            rq = '{FUNC_RAW, {3'($urandom), s}, 1'b0};
            msg.insert(msg.size(), rq);
            acc = bch_shift(acc, s);
         end
         // Data characters, all upper or all lower case.
         upper = 1'($urandom_range(1));
         repeat ($urandom_range(0, 10)) begin
            s = 5'($urandom);
            ch = char_of_symbol(s);
            if (upper && ch >= "a" && ch <= "z") begin
               ch = ch - 8'd32;
            end
            rq = '{FUNC_CHAR, ch, 1'b0};
            msg.insert(msg.size(), rq);
            acc = bch_shift(acc, s);
         end
         // A valid checksum in verify mode, rarely in create mode.
         if (model_mode == MODE_VERIFY || $urandom_range(9) == 0) begin
            code = checksum_code(acc);
            for (int k = 0; k < 6; k++) begin
               rq = '{FUNC_CHAR, char_of_symbol(code[5 * (5 - k) +: 5]), 1'b0};
               msg.insert(msg.size(), rq);
            end
         end
         if (pick < 35) begin
            rq = '{FUNC_CHAR, 8'($urandom), 1'b0};
            msg[$urandom_range(msg.size() - 1)] = rq;
         end
      end
      msg[msg.size() - 1].last = 1'b1;
      foreach (msg[i]) begin
         offer_request(msg[i], 1'b0);
      end
   endtask

   // Receiver: random stall, plus a long hold-off whenever one is asked for.
   initial begin
      int held;
      int holds_served;
      held = 0;
      holds_served = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            held = LONG_HOLD;
            holds_served++;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_symbol, rsp_symbol_char, rsp_checksum_ok, rsp_bad_char,
                 rsp_last_symbol};
         if (awaited_responses.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected response: sym %0d chr %02h ok %b bad %b last %b",
                        got.symbol, got.symbol_char, got.checksum_ok, got.bad_char,
                        got.last_symbol);
            end
         end else begin
            want = awaited_responses.pop_front();
            responses_checked++;
            if (got.symbol !== want.symbol || got.symbol_char !== want.symbol_char ||
                got.checksum_ok !== want.checksum_ok || got.bad_char !== want.bad_char ||
                got.last_symbol !== want.last_symbol) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("mismatch: want sym %0d chr %02h ok %b bad %b last %b",
                           want.symbol, want.symbol_char, want.checksum_ok,
                           want.bad_char, want.last_symbol);
                  $display("          got  sym %0d chr %02h ok %b bad %b last %b",
                           got.symbol, got.symbol_char, got.checksum_ok,
                           got.bad_char, got.last_symbol);
               end
            end
         end
      end
   end

   // Hard limit on the run.
   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   initial begin
      directed_row_type row;
      response_type     rs;
      logic [7:0]       ch;
      logic [5:0]       sym;
      int               target;
      int               wait_count;

      // Extremes and bad characters first, then the valid address A12UEL5L,
      // then checksum creation for the same prefix with and without a bad
      // character in front.
      directed_rows = '{
         '{MODE_VERIFY, '{FUNC_RAW,  8'h00, 1'b1}, 1'b1, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_RAW,  8'hff, 1'b1}, 1'b1, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, 8'hff, 1'b1}, 1'b1, 1'b1, 1'b1, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, 8'h00, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, 8'h80, 1'b1}, 1'b1, 1'b1, 1'b1, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "b",   1'b1}, 1'b1, 1'b1, 1'b1, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "q",   1'b1}, 1'b1, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_RAW,  8'he3, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_RAW,  8'h00, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_RAW,  8'h01, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "2",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "U",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "E",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "L",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "5",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_VERIFY, '{FUNC_CHAR, "L",   1'b1}, 1'b1, 1'b1, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'h03, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'h00, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'h01, 1'b1}, 1'b1, 1'b0, 1'b0, "2uel5l"},
         '{MODE_CREATE, '{FUNC_CHAR, "!",   1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'h23, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'he0, 1'b0}, 1'b0, 1'b0, 1'b0, NO_CHARS},
         '{MODE_CREATE, '{FUNC_RAW,  8'h21, 1'b1}, 1'b1, 1'b0, 1'b1, "2uel5l"},
         '{MODE_CREATE, '{FUNC_CHAR, "z",   1'b1}, 1'b0, 1'b0, 1'b0, NO_CHARS}
      };

      clock     = 1'b0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      req_valid = 1'b0;
      req_func  = 1'b0;
      req_value = 8'd0;
      req_last  = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // First idling pattern: sender rarely idle, receiver often stalled.
      send_idle_pct = 14;
      recv_idle_pct = 72;
      write_mode(MODE_VERIFY);

      // Directed table; typed rows carry their own expectation.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.mode != model_mode) begin
            write_mode(row.mode);
         end
         offer_request(row.rq, row.by_hand);
         if (row.by_hand) begin
            if (row.mode == MODE_VERIFY) begin
               rs = '{5'd0, 7'd0, row.hand_ok, row.hand_bad, 1'b1};
               awaited_responses.insert(awaited_responses.size(), rs);
            end else begin
               for (int k = 0; k < 6; k++) begin
                  ch = row.hand_chars[8 * (5 - k) +: 8];
                  sym = symbol_of_char(ch);
                  rs = '{sym[4:0], ch[6:0], 1'b0, row.hand_bad, k == 5};
                  awaited_responses.insert(awaited_responses.size(), rs);
               end
            end
         end
      end

      // Random messages in three idling stages, alternating the mode. Stray
      // requests may come before a mode write, so the mode changes under an open message.
      target = requests_sent;
      for (int stage = 0; stage < 3; stage++) begin
         send_idle_pct = (stage == 0) ? 14 : (stage == 1) ? 72 : 0;
         recv_idle_pct = (stage == 0) ? 72 : (stage == 1) ? 14 : 0;
         for (int phase = 0; phase < 3; phase++) begin
            if ($urandom_range(1)) begin
               repeat ($urandom_range(1, 3)) begin
                  row.rq = '{req_func_type'($urandom_range(1)), 8'($urandom), 1'b0};
                  offer_request(row.rq, 1'b0);
               end
            end
            write_mode(engine_mode_type'((stage + phase) % 2));
            // Long receiver hold-off while requests keep coming.
            if (phase == 1 && stage != 1) begin
               holds_asked++;
            end
            target += PHASE_ITEMS;
            while (requests_sent < target) begin
               offer_message();
            end
         end
      end
      req_valid <= 1'b0;

      // Wait for every expected response, then a little longer.
      wait_count = 0;
      while (awaited_responses.size() != 0 && wait_count < DRAIN_LIMIT) begin
         @(negedge clock);
         wait_count++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (awaited_responses.size() != 0) begin
         $display("responses never delivered: %0d", awaited_responses.size());
         errors += awaited_responses.size();
      end

      $display("Ran %0d requests and checked %0d responses in both modes.",
               requests_sent, responses_checked);
      $display("Verified %0d messages (%0d good), created %0d checksums, %0d had bad chars.",
               verify_msgs, verify_good, create_msgs, bad_msgs);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/bcs_pkg.sv
rtl/bcs_front.sv
rtl/bcs_queue.sv
rtl/bcs_back.sv
rtl/bech32_checksum_engine_core.sv
tb/sv/testbench.sv
